// ===== sv/skf_pkg.sv =====
// Shared widths, register codes and reset values for the scalar Kalman filter.
`timescale 1ns / 1ps

package skf_pkg;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic {
    REG_PROCESS_NOISE = 1'b0,
    REG_MEAS_NOISE    = 1'b1
  } reg_idx_t;

  localparam word_t PROCESS_NOISE_RST = 32'd1442;
  localparam word_t MEAS_NOISE_RST    = 32'd65536;

endpackage

// ===== sv/skf_div.sv =====
// Bit-serial restoring divider that forms the gain Ppred / (Ppred + R).
`timescale 1ns / 1ps

module skf_div import skf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  word_t              ppred,
  input  word_t              meas_noise,
  output logic [FRAC_BITS:0] gain,
  output logic               done
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam int REM_W = DATA_W + 2;

  logic [DATA_W:0]    denom;
  logic [REM_W-1:0]   rem;
  logic [FRAC_BITS:0] quo;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               zero_den;
  logic [REM_W:0]     trial;
  logic               ge;

  assign trial = {1'b0, rem} - {2'b00, denom};
  assign ge    = ~trial[REM_W];
  assign gain  = zero_den ? '0 : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(FRAC_BITS));
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        denom    <= {1'b0, ppred} + {1'b0, meas_noise};
        rem      <= {2'b00, ppred};
        quo      <= '0;
        zero_den <= (ppred == '0) && (meas_noise == '0);
      end else if (busy) begin
        quo <= {quo[FRAC_BITS-1:0], ge};
        if (ge) begin
          rem <= {trial[REM_W-2:0], 1'b0};
        end else begin
          rem <= {rem[REM_W-2:0], 1'b0};
        end
        if (cnt == CNT_W'(FRAC_BITS)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/skf_mul.sv =====
// Bit-serial shift-add multiplier that returns floor(a * b / 2^FRAC_BITS).
`timescale 1ns / 1ps

module skf_mul #(
  parameter int FRAC_BITS = 16,
  parameter int A_W       = 33
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [A_W-1:0] mcand,
  input  logic [FRAC_BITS:0]  mplier,
  output logic signed [A_W:0] product,
  output logic                done
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic signed [A_W-1:0] mc;
  logic [FRAC_BITS:0]    mbits;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic signed [A_W:0]   addend;
  logic signed [A_W:0]   sum;

  assign addend = mbits[0] ? {mc[A_W-1], mc} : '0;
  assign sum    = product + addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(FRAC_BITS));
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        mc      <= mcand;
        mbits   <= mplier;
        product <= '0;
      end else if (busy) begin
        mbits <= mbits >> 1;
        if (cnt == CNT_W'(FRAC_BITS)) begin
          product <= sum;
          busy    <= 1'b0;
        end else begin
          product <= sum >>> 1;
          cnt     <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/scalar_kalman_filter.sv =====
// Top level of the scalar Kalman filter: registers, sequencer and item handshakes.
`timescale 1ns / 1ps

// One measurement is taken at a time and produces one estimate. From its
// acceptance an item passes through these steps in order: the predicted
// covariance, the start of the divider, the bit-serial restoring divider that
// forms the gain, the start of the multipliers, the two shift-add multipliers
// that run side by side for the estimate and the covariance, and the loading of
// the result. The result sits in an output register, so the next measurement
// is accepted while it waits to be taken.

module scalar_kalman_filter import skf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // measurement
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // estimate
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int A_W = DATA_W + 1;
  localparam logic [FRAC_BITS:0] GAIN_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  state_t state;

  word_t process_noise;
  word_t meas_noise;
  word_t last_estimate;
  word_t error_cov;
  word_t meas;
  word_t ppred;
  logic [FRAC_BITS:0] gain;
  logic div_go;
  logic mul_go;

  logic [FRAC_BITS:0] div_gain;
  logic               div_done;
  logic signed [A_W:0] est_prod;
  logic signed [A_W:0] cov_prod;
  logic               est_done;
  logic               cov_done;

  logic [DATA_W:0]     ppred_sum;
  logic signed [A_W-1:0] diff;
  logic [A_W:0]        est_next;
  logic                out_free;
  reg_idx_t            widx;

  assign pready        = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign ppred_sum     = {1'b0, error_cov} + {1'b0, process_noise};
  assign diff          = $signed({meas[DATA_W-1], meas}) -
                         $signed({last_estimate[DATA_W-1], last_estimate});
  assign est_next      = {{2{last_estimate[DATA_W-1]}}, last_estimate} + est_prod;
  assign widx          = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (widx)
      REG_PROCESS_NOISE: prdata = process_noise;
      REG_MEAS_NOISE:    prdata = meas_noise;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= PROCESS_NOISE_RST;
      meas_noise    <= MEAS_NOISE_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_PROCESS_NOISE: process_noise <= pwdata;
        REG_MEAS_NOISE:    meas_noise    <= pwdata;
        default:           ;
      endcase
    end
  end

  skf_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_go),
    .ppred     (ppred),
    .meas_noise(meas_noise),
    .gain      (div_gain),
    .done      (div_done)
  );

  skf_mul #(
    .FRAC_BITS(FRAC_BITS),
    .A_W      (A_W)
  ) u_mul_est (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_go),
    .mcand  (diff),
    .mplier (gain),
    .product(est_prod),
    .done   (est_done)
  );

  skf_mul #(
    .FRAC_BITS(FRAC_BITS),
    .A_W      (A_W)
  ) u_mul_cov (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_go),
    .mcand  ($signed({1'b0, ppred})),
    .mplier (GAIN_ONE - gain),
    .product(cov_prod),
    .done   (cov_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      div_go        <= 1'b0;
      mul_go        <= 1'b0;
      m_axis_tvalid <= 1'b0;
      last_estimate <= '0;
      error_cov     <= '0;
    end else begin
      div_go <= (state == ST_PREP);
      mul_go <= (state == ST_DIV) && div_done;
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            meas  <= s_axis_tdata;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          ppred  <= ppred_sum[DATA_W] ? '1 : ppred_sum[DATA_W-1:0];
          state  <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            gain   <= div_gain;
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (est_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            last_estimate <= est_next[DATA_W-1:0];
            error_cov     <= cov_prod[DATA_W-1:0];
            m_axis_tdata  <= est_next[DATA_W-1:0];
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_done) |=> gain <= GAIN_ONE)
    else $error("gain above one");

  a_mul_sync: assert property (@(posedge clk) disable iff (rst)
    est_done == cov_done)
    else $error("multipliers out of step");

  a_cov_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> error_cov <= $past(ppred))
    else $error("covariance grew past its prediction");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> m_axis_tvalid && state == ST_IDLE)
    else $error("result not presented after update");

endmodule

// ===== tb/sv/tb_scalar_kalman_filter.sv =====
// Self-checking testbench for the scalar Kalman filter: directed table, then random phases.
`timescale 1ns / 1ps

module tb_scalar_kalman_filter;
  import skf_pkg::*;

  localparam int FRAC = 16;
  localparam logic [63:0] GAIN_ONE = 64'd1 << FRAC;
  localparam int DIR_N = 24;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 50;

  typedef enum logic {
    ROW_CFG,
    ROW_MEAS
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    word_t     q;
    word_t     r;
    word_t     meas;
    logic      fixed;
    word_t     est;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  word_t    q_reg = PROCESS_NOISE_RST;
  word_t    r_reg = MEAS_NOISE_RST;
  word_t    est_state = '0;
  word_t    cov_state = '0;
  word_t    phase_target = '0;
  word_t    pending_estimates[$];
  int       mismatches = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  dir_row_t dir_tab [DIR_N];

  scalar_kalman_filter #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  function automatic word_t kalman_update(input word_t meas);
    logic [63:0]        ppred;
    logic [63:0]        denom;
    logic [63:0]        gain;
    logic [63:0]        newp;
    logic signed [63:0] meas_s;
    logic signed [63:0] est_s;
    logic signed [63:0] diff;
    logic signed [63:0] prod;
    logic signed [63:0] step;
    logic signed [63:0] nxt;
    ppred = {32'd0, cov_state} + {32'd0, q_reg};
    if (ppred > 64'hFFFF_FFFF) begin
      ppred = 64'hFFFF_FFFF;
    end
    denom = ppred + {32'd0, r_reg};
    gain = '0;
    if (denom != 0) begin
      gain = (ppred << FRAC) / denom;
    end
    if (gain > GAIN_ONE) begin
      gain = GAIN_ONE;
    end
    meas_s = {{32{meas[31]}}, meas};
    est_s = {{32{est_state[31]}}, est_state};
    diff = meas_s - est_s;
    prod = $signed(gain) * diff;
    step = prod >>> FRAC;
    nxt = est_s + step;
    newp = ((GAIN_ONE - gain) * ppred) >> FRAC;
    est_state = nxt[31:0];
    cov_state = newp[31:0];
    return est_state;
  endfunction

  function automatic word_t next_measurement();
    word_t noise;
    word_t v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        noise = word_t'($urandom_range(0, 262143)) - 32'd131072;
        v = phase_target + noise;
      end
    endcase
    return v;
  endfunction

  task automatic send_meas(input word_t m, input logic use_fixed, input word_t fixed_est);
    word_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= m;
    do @(posedge clk); while (!s_axis_tready);
    pred = kalman_update(m);
    pending_estimates.push_back(use_fixed ? fixed_est : pred);
  endtask

  task automatic drain(input int extra);
    s_axis_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input word_t data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PROCESS_NOISE: q_reg = data;
      REG_MEAS_NOISE:    r_reg = data;
    endcase
    @(posedge clk);
  endtask

  task automatic apb_check(input reg_idx_t idx, input word_t want);
    word_t got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      mismatches++;
      $display("%0t: read of %s mismatch, expected %h, actual %h", $time, idx.name(), want, got);
    end
    @(posedge clk);
  endtask

  task automatic set_noise(input word_t q, input word_t r);
    apb_write(REG_PROCESS_NOISE, q);
    apb_write(REG_MEAS_NOISE, r);
    apb_check(REG_PROCESS_NOISE, q);
    apb_check(REG_MEAS_NOISE, r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_estimates.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected estimate, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          if (m_axis_tdata !== pending_estimates[0]) begin
            mismatches++;
            $display("%0t: estimate mismatch, expected %h, actual %h", $time,
                     pending_estimates[0], m_axis_tdata);
          end
          void'(pending_estimates.pop_front());
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_scalar_kalman_filter: done, errors");
    $finish;
  end

  initial begin
    dir_tab = '{
      '{ROW_MEAS, 32'h0,          32'h0,          32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h0001_0000, 1'b0, 32'h0},
      '{ROW_CFG,  32'h0,          32'h0,          32'h0,         1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h8000_0000, 1'b1, 32'h7FFF_FFFF},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
      '{ROW_CFG,  32'hFFFF_FFFF,  32'h0,          32'h0,         1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_MEAS, 32'h0,          32'h0,          32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_CFG,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'h0,         1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h7FFF_FFFF, 1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h8000_0000, 1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h1234_5678, 1'b0, 32'h0},
      '{ROW_CFG,  32'h0,          32'hFFFF_FFFF,  32'h0,         1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h8000_0000, 1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h7FFF_FFFF, 1'b0, 32'h0},
      '{ROW_CFG,  32'h1,          32'h1,          32'h0,         1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'hFFFF_0000, 1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h0000_0001, 1'b0, 32'h0},
      '{ROW_CFG,  PROCESS_NOISE_RST, MEAS_NOISE_RST, 32'h0,      1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h0002_0000, 1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'hFFFE_0000, 1'b0, 32'h0},
      '{ROW_MEAS, 32'h0,          32'h0,          32'h0000_0000, 1'b0, 32'h0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_check(REG_PROCESS_NOISE, PROCESS_NOISE_RST);
    apb_check(REG_MEAS_NOISE, MEAS_NOISE_RST);

    src_idle_pct = 17;
    snk_idle_pct = 69;
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain(4);
        set_noise(dir_tab[i].q, dir_tab[i].r);
      end else begin
        send_meas(dir_tab[i].meas, dir_tab[i].fixed, dir_tab[i].est);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain(4);
      if (p < 5) begin
        src_idle_pct = 17;
        snk_idle_pct = 69;
      end else if (p < 10) begin
        src_idle_pct = 69;
        snk_idle_pct = 17;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case ($urandom_range(0, 6))
        0: set_noise(32'h0, 32'h0);
        1: set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: set_noise($urandom, $urandom);
        3: set_noise($urandom_range(0, 4095), $urandom_range(0, 262143));
        4: set_noise(32'h0, $urandom);
        5: set_noise($urandom, 32'h0);
        default: set_noise(PROCESS_NOISE_RST, MEAS_NOISE_RST);
      endcase
      phase_target = $urandom;
      phase_target = {{2{phase_target[31]}}, phase_target[31:2]};
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_meas(next_measurement(), 1'b0, 32'h0);
      end
    end

    drain(48);
    if (mismatches == 0) begin
      $display("tb_scalar_kalman_filter: done, clean");
    end else begin
      $display("tb_scalar_kalman_filter: done, errors");
    end
    $finish;
  end

endmodule
